>>> rtl/core/blfb_pkg.sv
// ----------------------------------------------------------------------------
// blfb_pkg
// Types and codes shared by the line engine: command and pen codes, the job
// word that the front end queues for the back end, and back-end states.
// ----------------------------------------------------------------------------
package blfb_pkg;

	localparam int COORD_W = 12;
	localparam int STEP_W  = 11;
	localparam int ERR_W   = 14;

	typedef enum logic [1:0] {
		CMD_LINE = 2'd0,
		CMD_FILL = 2'd1,
		CMD_READ = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		PEN_CLEAR  = 2'd0,
		PEN_SET    = 2'd1,
		PEN_TOGGLE = 2'd2
	} pen_t;

	typedef enum logic [1:0] {
		OP_LINE = 2'd0,
		OP_FILL = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PIX,
		B_WR,
		B_FILL,
		B_RADDR,
		B_RDATA,
		B_DONE
	} back_state_t;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic [STEP_W-1:0]          steps;
		logic                       x_major;
		logic                       x_neg;
		logic                       y_neg;
		logic [11:0]                minor2;
		logic signed [ERR_W-1:0]    diff2;
		logic signed [ERR_W-1:0]    err;
		pen_t                       pen;
		logic [7:0]                 pattern;
		logic [9:0]                 read_index;
	} blfb_job_t;

endpackage

>>> rtl/core/blfb_ram.sv
// ----------------------------------------------------------------------------
// blfb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module blfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/blfb_fifo.sv
// ----------------------------------------------------------------------------
// blfb_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module blfb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/blfb_front.sv
// ----------------------------------------------------------------------------
// blfb_front
// Accepts command words, classifies them and sets up the line walk
// (deltas, directions, major axis, initial error) for the back end.
// ----------------------------------------------------------------------------
module blfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // start_x, start_y, end_x, end_y, pen_mode,
	                                         // fill_pattern, read_index
	input  logic [1:0]        s_axis_tuser,  // cmd
	output logic              q_push,
	output blfb_pkg::blfb_job_t q_job,
	input  logic              q_full
);

	import blfb_pkg::*;

	logic              valid_s1;
	logic [63:0]       data_s1;
	logic [1:0]        user_s1;

	logic signed [11:0] x0;
	logic signed [11:0] y0;
	logic signed [11:0] x1;
	logic signed [11:0] y1;
	logic signed [11:0] dx_raw;
	logic signed [11:0] dy_raw;
	logic [11:0]        dx_abs;
	logic [11:0]        dy_abs;
	logic [10:0]        major;
	logic [10:0]        minor;
	logic               x_major;
	logic               pen_ok;
	pen_t               pen_code;
	op_t                op;

	assign s_axis_tready = !valid_s1 || !q_full;
	assign q_push        = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser;
		end
	end

	assign x0 = $signed({data_s1[10], data_s1[10:0]});
	assign y0 = $signed({data_s1[21], data_s1[21:11]});
	assign x1 = $signed({data_s1[32], data_s1[32:22]});
	assign y1 = $signed({data_s1[43], data_s1[43:33]});
	assign pen_code = pen_t'(data_s1[45:44]);

	assign dx_raw  = x1 - x0;
	assign dy_raw  = y1 - y0;
	assign dx_abs  = dx_raw[11] ? 12'(-dx_raw) : dx_raw;
	assign dy_abs  = dy_raw[11] ? 12'(-dy_raw) : dy_raw;
	assign x_major = (dx_abs >= dy_abs);
	assign major   = x_major ? dx_abs[10:0] : dy_abs[10:0];
	assign minor   = x_major ? dy_abs[10:0] : dx_abs[10:0];

	always_comb begin
		pen_ok = 1'b0;
		unique case (pen_code) inside
			PEN_CLEAR, PEN_SET, PEN_TOGGLE: pen_ok = 1'b1;
			default:                        pen_ok = 1'b0;
		endcase
	end

	always_comb begin
		op = OP_NOP;
		unique case (cmd_code_t'(user_s1))
			CMD_LINE: op = pen_ok ? OP_LINE : OP_NOP;
			CMD_FILL: op = OP_FILL;
			CMD_READ: op = OP_READ;
			default:  op = OP_NOP;
		endcase
	end

	always_comb begin
		q_job            = '0;
		q_job.op         = op;
		q_job.x          = x0;
		q_job.y          = y0;
		q_job.steps      = major;
		q_job.x_major    = x_major;
		q_job.x_neg      = dx_raw[11];
		q_job.y_neg      = dy_raw[11];
		q_job.minor2     = {minor, 1'b0};
		q_job.diff2      = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
		q_job.err        = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		q_job.pen        = pen_code;
		q_job.pattern    = data_s1[53:46];
		q_job.read_index = data_s1[63:54];
	end

endmodule

>>> rtl/core/blfb_back.sv
// ----------------------------------------------------------------------------
// blfb_back
// Executes queued jobs against the frame store: walks a line pixel by pixel
// with a read-modify-write per on-screen pixel, sweeps a fill, or reads a
// byte (a no-op job only passes a zero result), then hands the result to the output register.
// ----------------------------------------------------------------------------
module blfb_back #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  blfb_pkg::blfb_job_t q_job,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata   // read_byte, pixels_drawn
);

	import blfb_pkg::*;

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);

	back_state_t state_q;
	back_state_t state_d;
	blfb_job_t   job_q;

	logic [AW-1:0] fill_addr_q;
	logic [7:0]    count_q;
	logic [7:0]    rbyte_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [7:0]    out_drawn_q;

	logic          pix_on;
	logic [AW-1:0] pix_addr;
	logic [7:0]    pix_mask;
	logic [7:0]    pix_byte;
	logic          read_ok;
	logic          fill_last;
	logic          step_en;
	logic          out_load;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign pix_on = !job_q.x[11] && (job_q.x[10:0] < 11'(SCREEN_WIDTH)) &&
	                !job_q.y[11] && (job_q.y[10:0] < 11'(SCREEN_HEIGHT));
	assign pix_addr = AW'(job_q.x[10:0]) + AW'(job_q.y[10:3]) * AW'(SCREEN_WIDTH);
	assign pix_mask = 8'(1) << job_q.y[2:0];
	assign read_ok  = ({2'b00, job_q.read_index} < 12'(STORE_BYTES));
	assign fill_last = (fill_addr_q == AW'(STORE_BYTES - 1));

	always_comb begin
		pix_byte = ram_rdata;
		case (job_q.pen)
			PEN_CLEAR:  pix_byte = ram_rdata & ~pix_mask;
			PEN_SET:    pix_byte = ram_rdata | pix_mask;
			PEN_TOGGLE: pix_byte = ram_rdata ^ pix_mask;
			default:    pix_byte = ram_rdata;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (q_job.op)
						OP_LINE: state_d = B_PIX;
						OP_FILL: state_d = B_FILL;
						OP_READ: state_d = B_RADDR;
						default: state_d = B_DONE;
					endcase
				end
			end
			B_PIX: begin
				if (pix_on) begin
					state_d = B_WR;
				end else if (job_q.steps == '0) begin
					state_d = B_DONE;
				end
			end
			B_WR:    state_d = (job_q.steps == '0) ? B_DONE : B_PIX;
			B_FILL:  state_d = fill_last ? B_DONE : B_FILL;
			B_RADDR: state_d = read_ok ? B_RDATA : B_DONE;
			B_RDATA: state_d = B_DONE;
			B_DONE:  state_d = (!out_valid_q || m_axis_tready) ? B_IDLE : B_DONE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		step_en   = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pix_addr;
		ram_wdata = pix_byte;
		ram_raddr = pix_addr;
		unique case (state_q)
			B_IDLE:  q_pop = !q_empty;
			B_PIX:   step_en = !pix_on;
			B_WR: begin
				ram_we  = 1'b1;
				step_en = 1'b1;
			end
			B_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_addr_q;
				ram_wdata = job_q.pattern;
			end
			B_RADDR: ram_raddr = AW'(job_q.read_index);
			B_RDATA: ram_raddr = AW'(job_q.read_index);
			B_DONE:  out_load = !out_valid_q || m_axis_tready;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q       <= q_job;
			fill_addr_q <= '0;
			count_q     <= '0;
			rbyte_q     <= '0;
		end else begin
			if (state_q == B_FILL) begin
				fill_addr_q <= fill_addr_q + 1'b1;
			end
			if (state_q == B_WR && count_q != 8'hFF) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == B_RDATA) begin
				rbyte_q <= ram_rdata;
			end
			if (step_en && job_q.steps != '0) begin
				job_q.steps <= job_q.steps - 1'b1;
				if (job_q.err[ERR_W-1]) begin
					job_q.err <= job_q.err + $signed({2'b00, job_q.minor2});
					if (job_q.x_major) begin
						job_q.x <= job_q.x_neg ? job_q.x - 12'sd1 : job_q.x + 12'sd1;
					end else begin
						job_q.y <= job_q.y_neg ? job_q.y - 12'sd1 : job_q.y + 12'sd1;
					end
				end else begin
					job_q.err <= job_q.err + job_q.diff2;
					job_q.x   <= job_q.x_neg ? job_q.x - 12'sd1 : job_q.x + 12'sd1;
					job_q.y   <= job_q.y_neg ? job_q.y - 12'sd1 : job_q.y + 12'sd1;
				end
			end
		end
		if (out_load) begin
			out_byte_q  <= rbyte_q;
			out_drawn_q <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_drawn_q, out_byte_q};

	blfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

>>> rtl/core/bresenham_line_frame_buffer_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_frame_buffer_top
// Monochrome frame-buffer line engine: line draw, pattern fill, byte read.
// Path: front-end register, two-entry job queue, back end, output register.
// Work: a line visits max(|dx|,|dy|)+1 pixels, read-modify-write per on-screen
//   pixel; a fill writes WIDTH*ceil(HEIGHT/8) bytes; a read past the store is 0.
// New words queue while the back end works; a stalled result holds the back end.
// Reset clears control state only; the frame store is undefined until filled.
// ----------------------------------------------------------------------------
module bresenham_line_frame_buffer_top #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y, pen_mode,
	                                    // fill_pattern, read_index
	input  logic [1:0]  s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // read_byte, pixels_drawn
);

	import blfb_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	blfb_job_t q_wjob;
	blfb_job_t q_rjob;

	blfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_push       (q_push),
		.q_job        (q_wjob),
		.q_full       (q_full)
	);

	blfb_fifo #(
		.WIDTH($bits(blfb_job_t)),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wjob),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rjob),
		.empty (q_empty)
	);

	blfb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_job        (q_rjob),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_one_result_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0))
		else $error("read byte and pixel count both nonzero");

endmodule

>>> tb/sv/frame_line_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_line_checker
// Watches both stream channels of the line engine and keeps a shadow copy of
// the frame store. For each accepted command word it predicts the result
// word (pixel count or read byte). It compares each returned word with the
// oldest prediction and counts mismatches and unexpected words.
// ----------------------------------------------------------------------------
module frame_line_checker #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y, pen_mode,
	                                    // fill_pattern, read_index
	input  logic [1:0]  s_axis_tuser,   // cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // read_byte, pixels_drawn
	output int          mismatch_count,
	output int          awaiting_count
);

	import blfb_pkg::*;

	localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

	typedef struct packed {
		logic [9:0]         read_index;
		logic [7:0]         fill_pattern;
		logic [1:0]         pen_mode;
		logic signed [10:0] end_y;
		logic signed [10:0] end_x;
		logic signed [10:0] start_y;
		logic signed [10:0] start_x;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] pixels_drawn;
		logic [7:0] read_byte;
	} result_word_t;

	logic [7:0]   shadow_store [0:STORE_BYTES-1];
	result_word_t result_q [$];
	result_word_t want;
	result_word_t got;

	function automatic int plot_pixel(int x, int y, pen_t pen);
		int idx;
		logic [7:0] mask;
		if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
			return 0;
		idx = x + (y >>> 3) * SCREEN_WIDTH;
		if (idx >= STORE_BYTES)
			return 0;
		mask = 8'd1 << (y & 7);
		case (pen)
			PEN_CLEAR: shadow_store[idx] = shadow_store[idx] & ~mask;
			PEN_SET:   shadow_store[idx] = shadow_store[idx] | mask;
			default:   shadow_store[idx] = shadow_store[idx] ^ mask;
		endcase
		return 1;
	endfunction

	function automatic logic [7:0] trace_line(int x0, int y0, int x1, int y1, pen_t pen);
		int dx, dy, sx, sy, major, minor, err, x, y, hits;
		bit x_major;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		sx = (x0 > x1) ? -1 : 1;
		sy = (y0 > y1) ? -1 : 1;
		x_major = (dx >= dy);
		major = x_major ? dx : dy;
		minor = x_major ? dy : dx;
		err = 2 * minor - major;
		x = x0;
		y = y0;
		hits = 0;
		for (int i = 0; i <= major; i++) begin
			hits += plot_pixel(x, y, pen);
			if (err < 0) begin
				err += 2 * minor;
				if (x_major)
					x += sx;
				else
					y += sy;
			end else begin
				err += 2 * minor - 2 * major;
				x += sx;
				y += sy;
			end
		end
		return (hits > 255) ? 8'd255 : hits[7:0];
	endfunction

	function automatic result_word_t predict_result(logic [1:0] cmd, cmd_word_t w);
		result_word_t r;
		r = '0;
		case (cmd)
			CMD_LINE: begin
				case (w.pen_mode)
					PEN_CLEAR, PEN_SET, PEN_TOGGLE:
						r.pixels_drawn = trace_line(w.start_x, w.start_y, w.end_x, w.end_y,
							pen_t'(w.pen_mode));
					default: ;
				endcase
			end
			CMD_FILL: begin
				for (int i = 0; i < STORE_BYTES; i++)
					shadow_store[i] = w.fill_pattern;
			end
			CMD_READ: begin
				if (int'(w.read_index) < STORE_BYTES)
					r.read_byte = shadow_store[w.read_index];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q.delete();
			mismatch_count = 0;
			awaiting_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h", $time, got);
					mismatch_count++;
				end else begin
					want = result_q.pop_front();
					if (got.read_byte !== want.read_byte) begin
						$display("%0t: read_byte expected %h got %h", $time,
							want.read_byte, got.read_byte);
						mismatch_count++;
					end
					if (got.pixels_drawn !== want.pixels_drawn) begin
						$display("%0t: pixels_drawn expected %0d got %0d", $time,
							want.pixels_drawn, got.pixels_drawn);
						mismatch_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(predict_result(s_axis_tuser, s_axis_tdata));
			awaiting_count <= result_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream stimulus for the frame-buffer line engine: a directed pass over
// extreme, clipped, degenerate and unknown commands, then a random mix of
// lines, fills, reads and dead words with random idle gaps on both channels. Checking
// is done by frame_line_checker.
// ----------------------------------------------------------------------------
module testbench;
	import blfb_pkg::*;

	localparam int          SCREEN_WIDTH  = 128;
	localparam int          SCREEN_HEIGHT = 64;
	localparam int          RANDOM_WORDS  = 1880;
	localparam int          SETTLE_CYCLES = 64;
	localparam longint      CYCLE_LIMIT   = 20_000_000;
	localparam logic [1:0]  CMD_NONE      = 2'd3;
	localparam logic [1:0]  PEN_NONE      = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	int          mismatch_count;
	int          awaiting_count;
	bit          no_idle;
	longint      cycle_count = 0;
	int          line_words, fill_words, read_words, dead_words;

	bresenham_line_frame_buffer_top #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	frame_line_checker #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatch_count(mismatch_count),
		.awaiting_count(awaiting_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [63:0] line_word(int sx, int sy, int ex, int ey,
		logic [1:0] pen, logic [7:0] pattern, logic [9:0] index);
		logic [31:0] a, b, c, d;
		a = sx;
		b = sy;
		c = ex;
		d = ey;
		return {index, pattern, pen, d[10:0], c[10:0], b[10:0], a[10:0]};
	endfunction

	function automatic int pick_coord(int span);
		if ($urandom_range(0, 99) < 5)
			return int'($urandom_range(0, 2047)) - 1024;
		return int'($urandom_range(0, span + 40)) - 20;
	endfunction

	task automatic send_word(logic [1:0] cmd, logic [63:0] data);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_LINE && data[45:44] != PEN_NONE)
			line_words++;
		else if (cmd == CMD_FILL)
			fill_words++;
		else if (cmd == CMD_READ)
			read_words++;
		else
			dead_words++;
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (awaiting_count == 0);
	endtask

	task automatic send_line(int sx, int sy, int ex, int ey, logic [1:0] pen);
		send_word(CMD_LINE, line_word(sx, sy, ex, ey, pen, 8'($urandom), 10'($urandom)));
	endtask

	task automatic send_read(int index);
		logic [31:0] i;
		i = index;
		send_word(CMD_READ, {i[9:0], 54'($urandom) ^ {22'd0, 32'($urandom)}});
	endtask

	// receiver: random stall before each result word
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		int pick, pen, x0, y0, x1, y1, last_index;
		no_idle       = 1'b0;
		line_words    = 0;
		fill_words    = 0;
		read_words    = 0;
		dead_words    = 0;
		last_index    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_LINE;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pass; the first word fills the whole store
		send_word(CMD_FILL, line_word(0, 0, 0, 0, PEN_SET, 8'h00, 10'd0));
		drain();
		send_line(0, 0, 127, 63, PEN_SET);
		send_line(5, 5, 5, 5, PEN_TOGGLE);
		send_line(10, 63, 12, 0, PEN_SET);
		send_line(-1024, -1024, 1023, 1023, PEN_SET);
		send_line(1023, -1024, -1024, 1023, PEN_CLEAR);
		send_line(200, 10, 300, 20, PEN_SET);
		send_line(0, 0, 50, 50, PEN_NONE);
		send_word(CMD_NONE, {$urandom, $urandom});
		send_line(0, 7, 127, 7, PEN_TOGGLE);
		send_line(3, -5, 3, 70, PEN_CLEAR);
		send_line(100, 40, 20, 10, PEN_SET);
		send_line(127, 63, -1024, 1023, PEN_TOGGLE);
		send_read(0);
		send_read(5);
		send_read(127);
		send_read(1023);
		send_read(130);
		send_word(CMD_FILL, line_word(0, 0, 0, 0, PEN_SET, 8'hA5, 10'd0));
		send_read(512);
		send_line(-1, -1, 128, 64, PEN_SET);
		send_read(0);
		send_word(CMD_FILL, line_word(0, 0, 0, 0, PEN_SET, 8'hFF, 10'd0));
		send_line(64, 0, 64, 63, PEN_CLEAR);
		send_read(64 + 7 * SCREEN_WIDTH);
		drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			no_idle = (n % 400) >= 320;
			if (n % 250 == 249)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_word(CMD_FILL, {$urandom, $urandom});
			end else if (pick < 6) begin
				send_word(CMD_NONE, {$urandom, $urandom});
			end else if (pick < 26) begin
				if ($urandom_range(0, 1))
					send_read(last_index);
				else
					send_read($urandom_range(0, 1023));
			end else begin
				x0  = pick_coord(SCREEN_WIDTH);
				y0  = pick_coord(SCREEN_HEIGHT);
				x1  = pick_coord(SCREEN_WIDTH);
				y1  = pick_coord(SCREEN_HEIGHT);
				pen = ($urandom_range(0, 99) < 5) ? int'(PEN_NONE) :
					int'($urandom_range(0, 2));
				if (x0 >= 0 && x0 < SCREEN_WIDTH && y0 >= 0 && y0 < SCREEN_HEIGHT)
					last_index = x0 + (y0 / 8) * SCREEN_WIDTH;
				send_line(x0, y0, x1, y1, pen[1:0]);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (awaiting_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d lines, %0d fills, %0d byte reads, %0d dead words",
			line_words, fill_words, read_words, dead_words);
		$display("in %0d cycles with random stalls on both channels", cycle_count);
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> bresenham_line_frame_buffer_top.f
rtl/core/blfb_pkg.sv
rtl/core/blfb_ram.sv
rtl/core/blfb_fifo.sv
rtl/core/blfb_front.sv
rtl/core/blfb_back.sv
rtl/core/bresenham_line_frame_buffer_top.sv
tb/sv/frame_line_checker.sv
tb/sv/testbench.sv
